>>> src/tti_pkg.sv
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, constants and ROM tables of the thermistor table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

   localparam int OVERSAMPLE    = 16;
   localparam int TABLE_ENTRIES = 53;
   localparam int ROM_ROWS      = 53;

   // rows actually searched: capped at the ROM and never below two
   localparam int ROWS = (TABLE_ENTRIES > ROM_ROWS) ? ROM_ROWS :
                         (TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES;

   localparam int ROW_W   = $clog2(ROM_ROWS);
   localparam int CODE_W  = 12;
   localparam int DEG_W   = 11;
   localparam int SCALE_W = 16;                   // scaled code and raw sum
   localparam int DT_W    = DEG_W + 1;            // signed degree step
   localparam int FRAC_W  = 4;                    // sixteenths of a degree
   localparam int NUM_W   = SCALE_W + FRAC_W + DT_W - 1;
   localparam int DEN_W   = SCALE_W + 1;          // signed code step
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int SUM_W   = NUM_W + 2;
   localparam int TEMP_W  = 15;
   localparam int TEMP_MIN = -480;
   localparam int TEMP_MAX = 16000;

   localparam logic [1:0] SENSOR_NTC3950 = 2'd0;
   localparam logic [1:0] SENSOR_WMT7029 = 2'd1;
   localparam logic [1:0] SENSOR_PT100   = 2'd2;

   typedef struct packed {
      logic load;
      logic search;
      logic mult;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic last_row;
   } status_type;

   localparam logic [CODE_W-1:0] CODE_NTC3950 [0:ROM_ROWS-1] = '{
      12'd4, 12'd91, 12'd118, 12'd136, 12'd169, 12'd201, 12'd236, 12'd270, 12'd309,
      12'd343, 12'd380, 12'd415, 12'd454, 12'd487, 12'd533, 12'd563, 12'd605, 12'd651,
      12'd687, 12'd766, 12'd839, 12'd918, 12'd1005, 12'd1098, 12'd1220, 12'd1330,
      12'd1472, 12'd1811, 12'd1729, 12'd1895, 12'd2068, 12'd2245, 12'd2394, 12'd2542,
      12'd2689, 12'd2832, 12'd2996, 12'd3175, 12'd3246, 12'd3337, 12'd3500, 12'd3537,
      12'd3605, 12'd3697, 12'd3775, 12'd3888, 12'd3927, 12'd3966, 12'd4005, 12'd4038,
      12'd4062, 12'd4083, 12'd4085};

   localparam logic [CODE_W-1:0] CODE_WMT7029 [0:ROM_ROWS-1] = '{
      12'd64, 12'd123, 12'd142, 12'd186, 12'd231, 12'd276, 12'd326, 12'd374, 12'd429,
      12'd476, 12'd529, 12'd578, 12'd632, 12'd678, 12'd741, 12'd782, 12'd840, 12'd901,
      12'd950, 12'd1056, 12'd1151, 12'd1254, 12'd1364, 12'd1481, 12'd1630, 12'd1760,
      12'd1924, 12'd2065, 12'd2209, 12'd2383, 12'd2557, 12'd2728, 12'd2866, 12'd2999,
      12'd3125, 12'd3243, 12'd3373, 12'd3509, 12'd3561, 12'd3626, 12'd3738, 12'd3763,
      12'd3808, 12'd3867, 12'd3915, 12'd3982, 12'd4005, 12'd4027, 12'd4049, 12'd4066,
      12'd4078, 12'd4089, 12'd4090};

   localparam logic [CODE_W-1:0] CODE_PT100 [0:ROM_ROWS-1] = '{
      12'd2897, 12'd2603, 12'd2544, 12'd2435, 12'd2350, 12'd2282, 12'd2220, 12'd2170,
      12'd2120, 12'd2083, 12'd2045, 12'd2013, 12'd1981, 12'd1956, 12'd1924, 12'd1905,
      12'd1879, 12'd1853, 12'd1834, 12'd1795, 12'd1762, 12'd1730, 12'd1697, 12'd1664,
      12'd1625, 12'd1592, 12'd1552, 12'd1519, 12'd1485, 12'd1445, 12'd1405, 12'd1357,
      12'd1330, 12'd1296, 12'd1262, 12'd1215, 12'd1187, 12'd1138, 12'd1117, 12'd1090,
      12'd1034, 12'd1020, 12'd992, 12'd950, 12'd907, 12'd829, 12'd794, 12'd751, 12'd693,
      12'd628, 12'd628, 12'd628, 12'd628};

   // degree column shared by all tables; only row 0 of NTC3950 differs
   localparam logic signed [DEG_W-1:0] DEG_COMMON [0:ROM_ROWS-1] = '{
      11'sd350, 11'sd300, 11'sd290, 11'sd272, 11'sd258, 11'sd247, 11'sd237, 11'sd229,
      11'sd221, 11'sd215, 11'sd209, 11'sd204, 11'sd199, 11'sd195, 11'sd190, 11'sd187,
      11'sd183, 11'sd179, 11'sd176, 11'sd170, 11'sd165, 11'sd160, 11'sd155, 11'sd150,
      11'sd144, 11'sd139, 11'sd133, 11'sd128, 11'sd123, 11'sd117, 11'sd111, 11'sd105,
      11'sd100, 11'sd95, 11'sd90, 11'sd85, 11'sd79, 11'sd72, 11'sd69, 11'sd65, 11'sd57,
      11'sd55, 11'sd51, 11'sd45, 11'sd39, 11'sd28, 11'sd23, 11'sd17, 11'sd9, 11'sd0,
      -11'sd10, -11'sd27, -11'sd30};

   localparam logic signed [DEG_W-1:0] DEG_NTC3950_ROW0 = 11'sd938;

   function automatic logic [CODE_W-1:0] code_rom(input logic [1:0] tbl,
                                                  input logic [ROW_W-1:0] row);
      logic [CODE_W-1:0] val;
      val = '0;
      if (row < ROW_W'(ROM_ROWS)) begin
         case (tbl)
            SENSOR_NTC3950: val = CODE_NTC3950[row];
            SENSOR_WMT7029: val = CODE_WMT7029[row];
            SENSOR_PT100:   val = CODE_PT100[row];
            default:        val = CODE_NTC3950[row];
         endcase
      end
      return val;
   endfunction

   function automatic logic signed [DEG_W-1:0] deg_rom(input logic [1:0] tbl,
                                                       input logic [ROW_W-1:0] row);
      logic signed [DEG_W-1:0] val;
      val = '0;
      if (row < ROW_W'(ROM_ROWS)) begin
         val = DEG_COMMON[row];
      end
      if (row == '0 && tbl == SENSOR_NTC3950) begin
         val = DEG_NTC3950_ROW0;
      end
      return val;
   endfunction

endpackage

>>> src/tti_ctrl.sv
// ----------------------------------------------------------------------------
// tti_ctrl
// Sequencer: table search, multiply, restoring divide, result hand-off.
// ----------------------------------------------------------------------------
module tti_ctrl
   import tti_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.hit || status.last_row) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult   = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/tti_dp.sv
// ----------------------------------------------------------------------------
// tti_dp
// Datapath: sensor select register, row search, multiplier, divider, output.
// ----------------------------------------------------------------------------
module tti_dp
   import tti_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [SCALE_W-1:0]       req_raw_sum,
   input  logic                     csr_write,
   input  logic [1:0]               csr_sensor_type,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_clamped
);

   logic [1:0]                sensor_type_ff;
   logic [SCALE_W-1:0]        raw_ff;
   logic [ROW_W-1:0]          row_ff;
   logic [SCALE_W-1:0]        da_ff;
   logic signed [DT_W-1:0]    dt_ff;
   logic signed [DEN_W-1:0]   den_ff;
   logic signed [DEG_W-1:0]   base_ff;
   logic                      clamped_ff;
   logic                      neg_ff;
   logic                      den_zero_ff;
   logic [SCALE_W-1:0]        den_mag_ff;
   logic [NUM_W-1:0]          quo_ff;
   logic [SCALE_W-1:0]        rem_ff;
   logic signed [TEMP_W-1:0]  temp_ff;
   logic                      out_clamped_ff;

   logic [1:0]                tbl;
   logic                      falling;
   logic [SCALE_W-1:0]        code_cur, code_prev;
   logic signed [DEG_W-1:0]   deg_cur, deg_prev;
   logic                      hit;
   logic [SCALE_W-1:0]        da;
   logic signed [DEN_W-1:0]   den;
   logic [DT_W-2:0]           dt_mag;
   logic [DT_W-1:0]           dt_neg;
   logic [DEN_W-1:0]          den_neg;
   logic [SCALE_W:0]          trial;
   logic                      fits;
   logic [NUM_W-1:0]          q_mag;
   logic signed [SUM_W-1:0]   q_s, base_s, sum;
   logic signed [TEMP_W-1:0]  sat;

   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(TEMP_MIN);
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(TEMP_MAX);

   function automatic logic req_gt(input logic [SCALE_W-1:0] x,
                                   input logic [SCALE_W-1:0] y);
      return x > y;
   endfunction

   assign tbl     = (sensor_type_ff == SENSOR_PT100) ? SENSOR_PT100 :
                    (sensor_type_ff == SENSOR_WMT7029) ? SENSOR_WMT7029 : SENSOR_NTC3950;
   assign falling = (sensor_type_ff == SENSOR_PT100);

   always_comb begin
      code_cur  = SCALE_W'(code_rom(tbl, row_ff) * OVERSAMPLE);
      code_prev = SCALE_W'(code_rom(tbl, row_ff - 1'b1) * OVERSAMPLE);
      deg_cur   = deg_rom(tbl, row_ff);
      deg_prev  = deg_rom(tbl, row_ff - 1'b1);
      if (falling) begin
         hit = req_gt(raw_ff, code_cur);
         da  = raw_ff - code_cur;
         den = $signed({1'b0, code_prev}) - $signed({1'b0, code_cur});
      end else begin
         hit = req_gt(code_cur, raw_ff);
         da  = code_cur - raw_ff;
         den = $signed({1'b0, code_cur}) - $signed({1'b0, code_prev});
      end
   end

   assign status.hit      = hit;
   assign status.last_row = (row_ff == ROW_W'(ROWS - 1));

   assign dt_neg  = -dt_ff;
   assign dt_mag  = dt_ff[DT_W-1] ? dt_neg[DT_W-2:0] : dt_ff[DT_W-2:0];
   assign den_neg = -den_ff;

   // one restoring divide step
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, den_mag_ff});

   always_comb begin
      q_mag  = den_zero_ff ? '0 : quo_ff;
      q_s    = neg_ff ? -$signed({2'b00, q_mag}) : $signed({2'b00, q_mag});
      base_s = SUM_W'($signed({base_ff, {FRAC_W{1'b0}}}));
      sum    = base_s + q_s;
      if (sum < SUM_MIN) begin
         sat = TEMP_W'(SUM_MIN);
      end else if (sum > SUM_MAX) begin
         sat = TEMP_W'(SUM_MAX);
      end else begin
         sat = sum[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_type_ff <= SENSOR_NTC3950;
      end else if (csr_write) begin
         sensor_type_ff <= csr_sensor_type;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= req_raw_sum;
         row_ff <= ROW_W'(1);
      end
      if (cmd.search) begin
         if (hit) begin
            da_ff      <= da;
            dt_ff      <= DT_W'(deg_prev) - DT_W'(deg_cur);
            den_ff     <= den;
            base_ff    <= deg_cur;
            clamped_ff <= 1'b0;
         end else if (status.last_row) begin
            // no match: last temperature, zero fraction
            da_ff      <= '0;
            dt_ff      <= '0;
            den_ff     <= '0;
            base_ff    <= deg_cur;
            clamped_ff <= 1'b1;
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end
      if (cmd.mult) begin
         quo_ff      <= NUM_W'({da_ff, {FRAC_W{1'b0}}} * dt_mag);
         rem_ff      <= '0;
         neg_ff      <= dt_ff[DT_W-1] ^ den_ff[DEN_W-1];
         den_zero_ff <= (den_ff == '0);
         den_mag_ff  <= den_ff[DEN_W-1] ? den_neg[SCALE_W-1:0] : den_ff[SCALE_W-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= fits ? SCALE_W'(trial - {1'b0, den_mag_ff}) : trial[SCALE_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
      if (cmd.finish) begin
         temp_ff        <= sat;
         out_clamped_ff <= clamped_ff;
      end
   end

   assign rsp_temperature = temp_ff;
   assign rsp_clamped     = out_clamped_ff;

endmodule

>>> src/thermistor_table_interpolator.sv
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// ADC sum to temperature by table search and linear interpolation.
//
//   channel | direction | handshake        | payload
//   req     | in        | valid / stall    | raw_sum[15:0]
//   rsp     | out       | valid / stall    | temperature[14:0] signed, clamped
//   csr     | in        | valid / ready    | sensor_type[1:0]
//
// A request visits k = 1..52 rows in the serial table search, then takes
// one multiply step and a 31-step restoring divide.
// One request is in work at a time; the result register lets the next
// request start while a result is stalled on rsp.
// Reset is synchronous and clears the sensor select to table 0.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator
   import tti_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SCALE_W-1:0]       req_raw_sum,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_clamped,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_sensor_type
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tti_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_raw_sum     (req_raw_sum),
      .csr_write       (csr_valid && csr_ready),
      .csr_sensor_type (csr_sensor_type),
      .cmd             (cmd),
      .status          (status),
      .rsp_temperature (rsp_temperature),
      .rsp_clamped     (rsp_clamped)
   );

endmodule
